// ===== rtl/fst_pkg.sv =====
package fst_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_PROCS_DEF = 32;
  localparam int unsigned TIME_BITS_DEF = 16;

  // Field widths on the channels.
  localparam int unsigned IN_W    = 16;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned TIME_W  = 22;
  localparam int unsigned TOTAL_W = 27;

  // Completion is carried unsaturated. Sixty-four bursts of 16-bit length after
  // a 16-bit arrival stay below 2^23.
  localparam int unsigned DONE_W = 23;

  localparam logic [TIME_W-1:0]  TIME_FIELD_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_FIELD_MAX = '1;

  typedef struct packed {
    logic [DONE_W-1:0]  prev_done;
    logic [IN_W-1:0]    arrival;
    logic [IN_W-1:0]    burst;
    logic [TOTAL_W-1:0] tot_wait;
    logic [TOTAL_W-1:0] tot_turn;
  } alu_op_t;

  typedef struct packed {
    logic               later;
    logic [DONE_W-1:0]  done_raw;
    logic [TIME_W-1:0]  done_sat;
    logic [TIME_W-1:0]  wait_sat;
    logic [TIME_W-1:0]  turn_sat;
    logic [TOTAL_W-1:0] tot_wait;
    logic [TOTAL_W-1:0] tot_turn;
  } alu_res_t;

endpackage

// ===== rtl/fst_proc_if.sv =====
interface fst_proc_if;
  import fst_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] arrival_time;
  logic [IN_W-1:0] burst_time;
  logic            last_process;

  modport source (output valid, arrival_time, burst_time, last_process, input ready);
  modport sink   (input valid, arrival_time, burst_time, last_process, output ready);
endinterface

// ===== rtl/fst_res_if.sv =====
interface fst_res_if;
  import fst_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   position;
  logic [IN_W-1:0]    sorted_arrival;
  logic [IN_W-1:0]    sorted_burst;
  logic [TIME_W-1:0]  completion_time;
  logic [TIME_W-1:0]  waiting_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic [TOTAL_W-1:0] total_waiting;
  logic [TOTAL_W-1:0] total_turnaround;
  logic               end_of_run;
  logic               overflow_flag;

  modport source (output valid, position, sorted_arrival, sorted_burst, completion_time,
                  waiting_time, turnaround_time, total_waiting, total_turnaround,
                  end_of_run, overflow_flag, input ready);
  modport sink   (input valid, position, sorted_arrival, sorted_burst, completion_time,
                  waiting_time, turnaround_time, total_waiting, total_turnaround,
                  end_of_run, overflow_flag, output ready);
endinterface

// ===== rtl/fcfs_schedule_timing.sv =====
// First-come-first-served schedule timing.
// proc_i carries one process per beat: arrival time, burst time and a last flag.
// Each process is placed in an on-chip store, kept stably sorted by arrival,
// by an insertion step that reads, compares and moves one entry at a time
// through a single read port and a single write port. proc_i.ready stays low
// while a process is being inserted. A process that arrives while the store
// is full is dropped and the run is marked as overflowed.
// After the beat flagged last has been stored, res_o gives one beat per stored
// process in arrival order; each beat takes a store read, one pass through
// the shared timing unit, and the output register. The timing unit also does
// the compare of the insertion step.
// When the receiver stalls, the result is held in the output register and the
// sequencer waits; proc_i stays not ready until the whole run has gone.
// The final beat of a run carries end_of_run, after which the store counts as
// empty. Reset empties the store and clears the overflow mark; the store
// contents themselves need no clearing.
module fcfs_schedule_timing #(
  parameter int unsigned MAX_PROCS = fst_pkg::MAX_PROCS_DEF,
  parameter int unsigned TIME_BITS = fst_pkg::TIME_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fst_proc_if.sink        proc_i,
  fst_res_if.source       res_o
);
  import fst_pkg::*;

  localparam int unsigned SW     = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
  localparam int unsigned ADDR_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_RD    = 3'd1;
  localparam logic [2:0] S_INS_CMP   = 3'd2;
  localparam logic [2:0] S_INS_WR    = 3'd3;
  localparam logic [2:0] S_EMIT_RD   = 3'd4;
  localparam logic [2:0] S_EMIT_CALC = 3'd5;
  localparam logic [2:0] S_EMIT_OUT  = 3'd6;

  // Store: burst in the low half, arrival in the high half.
  logic [2*SW-1:0] mem [MAX_PROCS];
  logic [2*SW-1:0] rd_q;
  logic            rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic            wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [2*SW-1:0] wr_data;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [ADDR_W-1:0] j_q, j_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic [SW-1:0]     new_arr_q, new_arr_d;
  logic [SW-1:0]     new_bur_q, new_bur_d;
  logic              new_last_q, new_last_d;
  logic [DONE_W-1:0]  prev_q, prev_d;
  logic [TOTAL_W-1:0] tot_w_q, tot_w_d;
  logic [TOTAL_W-1:0] tot_t_q, tot_t_d;
  logic              out_valid_q, out_valid_d;
  logic              load_out;

  logic [POS_W-1:0]   pos_q;
  logic [IN_W-1:0]    s_arr_q, s_bur_q;
  logic [TIME_W-1:0]  done_q, wait_q, turn_q;
  logic [TOTAL_W-1:0] ow_q, ot_q;
  logic               eor_q, ovf_q;

  logic [SW-1:0] rd_arr, rd_bur;
  logic          in_beat, out_beat, is_final;
  alu_op_t       alu_op;
  alu_res_t      alu_res;

  assign rd_arr = rd_q[2*SW-1:SW];
  assign rd_bur = rd_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // During insertion the unit compares a stored arrival against the new one;
  // during emission it works out the timing of one stored process.
  always_comb begin
    alu_op = '0;
    if (state_q == S_INS_CMP) begin
      alu_op.prev_done = DONE_W'(rd_arr);
      alu_op.arrival   = IN_W'(new_arr_q);
    end else begin
      alu_op.prev_done = prev_q;
      alu_op.arrival   = IN_W'(rd_arr);
      alu_op.burst     = IN_W'(rd_bur);
      alu_op.tot_wait  = tot_w_q;
      alu_op.tot_turn  = tot_t_q;
    end
  end

  fst_time_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  assign proc_i.ready = (state_q == S_IDLE);
  assign in_beat      = proc_i.valid && proc_i.ready;
  assign out_beat     = out_valid_q && res_o.ready;
  assign is_final     = (CNT_W'(k_q) + CNT_W'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    j_d         = j_q;
    k_d         = k_q;
    new_arr_d   = new_arr_q;
    new_bur_d   = new_bur_q;
    new_last_d  = new_last_q;
    prev_d      = prev_q;
    tot_w_d     = tot_w_q;
    tot_t_d     = tot_t_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = j_q - ADDR_W'(1);
    wr_en       = 1'b0;
    wr_addr     = j_q;
    wr_data     = {new_arr_q, new_bur_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          new_arr_d  = proc_i.arrival_time[SW-1:0];
          new_bur_d  = proc_i.burst_time[SW-1:0];
          new_last_d = proc_i.last_process;
          k_d        = '0;
          if (count_q < CNT_W'(MAX_PROCS)) begin
            j_d     = ADDR_W'(count_q);
            state_d = (count_q == '0) ? S_INS_WR : S_INS_RD;
          end else begin
            dropped_d = 1'b1;
            if (proc_i.last_process) begin
              state_d = S_EMIT_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        rd_en   = 1'b1;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (alu_res.later) begin
          wr_en   = 1'b1;
          wr_data = rd_q;
          j_d     = j_q - ADDR_W'(1);
          state_d = (j_q == ADDR_W'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        state_d = new_last_q ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = k_q;
        state_d = S_EMIT_CALC;
      end
      S_EMIT_CALC: begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
        prev_d      = alu_res.done_raw;
        tot_w_d     = alu_res.tot_wait;
        tot_t_d     = alu_res.tot_turn;
        state_d     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_beat) begin
          out_valid_d = 1'b0;
          if (is_final) begin
            count_d   = '0;
            dropped_d = 1'b0;
            prev_d    = '0;
            tot_w_d   = '0;
            tot_t_d   = '0;
            state_d   = S_IDLE;
          end else begin
            k_d     = k_q + ADDR_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      new_last_q  <= 1'b0;
      prev_q      <= '0;
      tot_w_q     <= '0;
      tot_t_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      j_q         <= j_d;
      k_q         <= k_d;
      new_last_q  <= new_last_d;
      prev_q      <= prev_d;
      tot_w_q     <= tot_w_d;
      tot_t_q     <= tot_t_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_arr_q <= new_arr_d;
    new_bur_q <= new_bur_d;
    if (load_out) begin
      pos_q   <= POS_W'(k_q);
      s_arr_q <= IN_W'(rd_arr);
      s_bur_q <= IN_W'(rd_bur);
      done_q  <= alu_res.done_sat;
      wait_q  <= alu_res.wait_sat;
      turn_q  <= alu_res.turn_sat;
      ow_q    <= alu_res.tot_wait;
      ot_q    <= alu_res.tot_turn;
      eor_q   <= is_final;
      ovf_q   <= dropped_q;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.position         = pos_q;
  assign res_o.sorted_arrival   = s_arr_q;
  assign res_o.sorted_burst     = s_bur_q;
  assign res_o.completion_time  = done_q;
  assign res_o.waiting_time     = wait_q;
  assign res_o.turnaround_time  = turn_q;
  assign res_o.total_waiting    = ow_q;
  assign res_o.total_turnaround = ot_q;
  assign res_o.end_of_run       = eor_q;
  assign res_o.overflow_flag    = ovf_q;

  a_out_only_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_EMIT_OUT))
    else $error("result valid outside the emit wait state");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PROCS))
    else $error("entry count beyond capacity");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && eor_q) |=> (count_q == '0) && !dropped_q && (state_q == S_IDLE))
    else $error("store not cleared after the final beat of a run");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_RD) |-> (CNT_W'(k_q) < count_q))
    else $error("emission reads beyond the stored entries");

endmodule

// ===== rtl/fst_time_alu.sv =====
module fst_time_alu (
  input  fst_pkg::alu_op_t  op_i,
  output fst_pkg::alu_res_t res_o
);
  import fst_pkg::*;

  logic [DONE_W-1:0]    arr_ext;
  logic [DONE_W-1:0]    start;
  logic [DONE_W-1:0]    wait_raw;
  logic [DONE_W-1:0]    turn_raw;
  logic [TOTAL_W:0]     sum_wait;
  logic [TOTAL_W:0]     sum_turn;

  // The compare also serves the insertion sort: there prev_done holds a stored
  // arrival and the flag says it is later than the new one.
  assign arr_ext     = DONE_W'(op_i.arrival);
  assign res_o.later = op_i.prev_done > arr_ext;

  assign start    = res_o.later ? op_i.prev_done : arr_ext;
  assign wait_raw = start - arr_ext;
  assign res_o.done_raw = start + DONE_W'(op_i.burst);
  assign turn_raw = wait_raw + DONE_W'(op_i.burst);

  assign res_o.done_sat = (res_o.done_raw > DONE_W'(TIME_FIELD_MAX)) ? TIME_FIELD_MAX
                                                                     : res_o.done_raw[TIME_W-1:0];
  assign res_o.wait_sat = (wait_raw > DONE_W'(TIME_FIELD_MAX)) ? TIME_FIELD_MAX
                                                               : wait_raw[TIME_W-1:0];
  assign res_o.turn_sat = (turn_raw > DONE_W'(TIME_FIELD_MAX)) ? TIME_FIELD_MAX
                                                               : turn_raw[TIME_W-1:0];

  assign sum_wait = (TOTAL_W+1)'(op_i.tot_wait) + (TOTAL_W+1)'(res_o.wait_sat);
  assign sum_turn = (TOTAL_W+1)'(op_i.tot_turn) + (TOTAL_W+1)'(res_o.turn_sat);

  assign res_o.tot_wait = sum_wait[TOTAL_W] ? TOTAL_FIELD_MAX : sum_wait[TOTAL_W-1:0];
  assign res_o.tot_turn = sum_turn[TOTAL_W] ? TOTAL_FIELD_MAX : sum_turn[TOTAL_W-1:0];

endmodule
